/* sv/hlt_pkg.sv */
`timescale 1ns / 1ps

package hlt_pkg;

  // Table geometry and field widths
  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned ADDR_BITS     = 24;
  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned CFG_BITS      = 32;
  localparam int unsigned IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [IDX_BITS-1:0]  IDX_LAST      = IDX_BITS'(TABLE_ENTRIES - 1);
  localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = TIME_BITS'(1000000);

  typedef enum logic [1:0] {
    FN_HEARTBEAT = 2'd0,
    FN_SCAN      = 2'd1,
    FN_LIST      = 2'd2,
    FN_FIRST     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_LISTED   = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_NOTHING  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_PASS,
    CS_COMMIT,
    CS_EMIT
  } ctl_state_e;

  typedef struct packed {
    func_e                func;
    logic [ADDR_BITS-1:0] device_addr;
    logic [TIME_BITS-1:0] now;
  } in_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] result_addr;
    status_e              status;
    logic                 last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic                capture;
    logic                step;
    logic [IDX_BITS-1:0] idx;
    logic                commit;
    logic                emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rescan;
    logic res_last;
    logic out_free;
  } sts_t;

endpackage

/* sv/hlt_ctrl.sv */
`timescale 1ns / 1ps

module hlt_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  hlt_pkg::sts_t sts_i,
  output hlt_pkg::cmd_t cmd_o
);
  import hlt_pkg::*;

  ctl_state_e          state_q, state_d;
  logic [IDX_BITS-1:0] idx_q, idx_d;

  // Hold state and slot counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_valid_i) state_d = CS_PASS;
      end
      CS_PASS: begin
        if (idx_q == IDX_LAST) state_d = CS_COMMIT;
      end
      CS_COMMIT: begin
        state_d = sts_i.rescan ? CS_PASS : CS_EMIT;
      end
      CS_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.res_last ? CS_IDLE : CS_PASS;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Advance the slot counter through one pass
  always_comb begin
    if (state_q == CS_PASS && idx_q != IDX_LAST) begin
      idx_d = idx_q + 1'b1;
    end else begin
      idx_d = '0;
    end
  end

  // Commands
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.idx     = idx_q;
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      CS_PASS:   cmd_o.step   = 1'b1;
      CS_COMMIT: cmd_o.commit = 1'b1;
      CS_EMIT:   cmd_o.emit   = sts_i.out_free;
      default: ;
    endcase
  end

  a_pass_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CS_PASS && idx_q == IDX_LAST |=> state_q == CS_COMMIT)
    else $error("pass did not end in commit");

  a_accept_starts_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == CS_PASS && idx_q == '0)
    else $error("accepted transaction did not start a pass at slot zero");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != CS_PASS |-> idx_q == '0)
    else $error("slot counter moved outside a pass");

endmodule

/* sv/hlt_datapath.sv */
`timescale 1ns / 1ps

module hlt_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hlt_pkg::CFG_BITS-1:0]   cfg_data_i,
  input  hlt_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output hlt_pkg::out_t                  out_data_o,
  input  hlt_pkg::cmd_t                  cmd_i,
  output hlt_pkg::sts_t                  sts_o
);
  import hlt_pkg::*;

  // Table: valid bits reset, contents undefined until written
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [ADDR_BITS-1:0]     addr_q [TABLE_ENTRIES];
  logic [TIME_BITS-1:0]     seen_q [TABLE_ENTRIES];

  logic [TIME_BITS-1:0] timeout_q;
  in_t                  item_q;
  logic                 use_floor_q;
  logic [ADDR_BITS-1:0] cur_addr_q;

  logic                 match_found_q, free_found_q, best_found_q;
  logic [IDX_BITS-1:0]  match_idx_q, free_idx_q, best_idx_q;
  logic [ADDR_BITS-1:0] best_addr_q;

  out_t res_q, res_d;
  logic out_valid_q;
  out_t out_q;

  logic                 rd_valid;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [TIME_BITS-1:0] rd_seen;
  logic [TIME_BITS-1:0] age;
  logic                 is_hb, hit_match, hit_free, cand, better;
  logic                 rescan, clr;

  // Read the slot under the counter
  assign rd_valid = valid_q[cmd_i.idx];
  assign rd_addr  = addr_q[cmd_i.idx];
  assign rd_seen  = seen_q[cmd_i.idx];

  // Compare the slot against the transaction
  always_comb begin
    age       = item_q.now - rd_seen;
    is_hb     = (item_q.func == FN_HEARTBEAT);
    hit_match = rd_valid && (rd_addr == item_q.device_addr);
    hit_free  = !rd_valid;
    unique case (item_q.func)
      FN_HEARTBEAT: cand = 1'b0;
      FN_SCAN:      cand = rd_valid && (age > timeout_q);
      FN_LIST,
      FN_FIRST:     cand = rd_valid && (!use_floor_q || rd_addr > cur_addr_q);
      default:      cand = 1'b0;
    endcase
    better = cand && (!best_found_q || rd_addr < best_addr_q);
  end

  assign rescan = (item_q.func == FN_LIST) && !use_floor_q && best_found_q;
  assign clr    = cmd_i.capture || (cmd_i.commit && rescan) || (cmd_i.emit && !res_q.last);

  // Hold timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= TIME_BITS'(cfg_data_i);
    end
  end

  // Capture the transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
  end

  // Search flags and list floor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      best_found_q  <= 1'b0;
      use_floor_q   <= 1'b0;
    end else begin
      if (clr) begin
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
        best_found_q  <= 1'b0;
      end else if (cmd_i.step) begin
        if (is_hb && hit_match) match_found_q <= 1'b1;
        if (is_hb && hit_free)  free_found_q  <= 1'b1;
        if (better)             best_found_q  <= 1'b1;
      end
      if (cmd_i.capture) begin
        use_floor_q <= 1'b0;
      end else if (cmd_i.commit && rescan) begin
        use_floor_q <= 1'b1;
      end
    end
  end

  // Search results: keep the first match and free slot, the lowest candidate
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && !clr) begin
      if (is_hb && hit_match && !match_found_q) match_idx_q <= cmd_i.idx;
      if (is_hb && hit_free && !free_found_q)   free_idx_q  <= cmd_i.idx;
      if (better) begin
        best_idx_q  <= cmd_i.idx;
        best_addr_q <= rd_addr;
      end
    end
    if ((cmd_i.commit && rescan) || (cmd_i.emit && !res_q.last)) begin
      cur_addr_q <= best_addr_q;
    end
  end

  // Form the result at commit
  always_comb begin
    res_d = '{result_addr: '0, status: ST_NOTHING, last: 1'b1};
    unique case (item_q.func)
      FN_HEARTBEAT: begin
        res_d.result_addr = item_q.device_addr;
        if (match_found_q)     res_d.status = ST_UPDATED;
        else if (free_found_q) res_d.status = ST_INSERTED;
        else                   res_d.status = ST_DROPPED;
      end
      FN_SCAN: begin
        if (best_found_q) begin
          res_d.result_addr = best_addr_q;
          res_d.status      = ST_REMOVED;
        end
      end
      FN_LIST: begin
        if (use_floor_q) begin
          res_d.result_addr = cur_addr_q;
          res_d.status      = ST_LISTED;
          res_d.last        = !best_found_q;
        end
      end
      FN_FIRST: begin
        if (best_found_q) begin
          res_d.result_addr = best_addr_q;
          res_d.status      = ST_LISTED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) res_q <= res_d;
  end

  // Table valid bits: set on insert, drop on expiry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.commit) begin
      if (is_hb && !match_found_q && free_found_q) valid_q[free_idx_q] <= 1'b1;
      if (item_q.func == FN_SCAN && best_found_q)  valid_q[best_idx_q] <= 1'b0;
    end
  end

  // Table contents
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && is_hb) begin
      if (match_found_q) begin
        seen_q[match_idx_q] <= item_q.now;
      end else if (free_found_q) begin
        addr_q[free_idx_q] <= item_q.device_addr;
        seen_q[free_idx_q] <= item_q.now;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_q <= res_q;
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.rescan    = rescan;
  assign sts_o.res_last  = res_q.last;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken transaction");

  a_scan_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && item_q.func == FN_SCAN && best_found_q
      |=> !valid_q[$past(best_idx_q)])
    else $error("expired entry still valid after removal");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("waiting result changed before it was taken");

endmodule

/* sv/heartbeat_liveness_table.sv */
`timescale 1ns / 1ps
// Channel  Handshake                Payload
// in       in_valid_i / in_ready_o  in_data_i  (func, device_addr, now)
// out      out_valid_o / out_ready_i out_data_o (result_addr, status, last)
// cfg      cfg_we_i                 cfg_data_i (timeout_ticks)
//
// Each pass visits the sixteen slots one per cycle through a single compare unit.
// Heartbeat, scan and first: an accept, a pass over all slots, a commit and an emit.
// List of k entries: an accept, k+1 passes each ending in a commit, and k emits; empty as for first.
// Reset clears the valid bits at once; timeout returns to 1000000 ticks.
// A waiting result sits in the output register; the next transaction is taken
// meanwhile, and only a further result stalls until the output is free.

module heartbeat_liveness_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [hlt_pkg::CFG_BITS-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  hlt_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output hlt_pkg::out_t                out_data_o
);
  import hlt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hlt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import hlt_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 1000000;
  localparam int unsigned HOLD_OFF      = 400;
  localparam int unsigned TAIL_CYCLES   = 40;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned PHASE_ITEMS   = 96;
  localparam int unsigned POOL_MAX      = 24;
  localparam int unsigned DIR_ROWS      = 26;

  typedef struct {
    func_e                f;
    logic [ADDR_BITS-1:0] a;
    logic [TIME_BITS-1:0] t;
    bit                   typed;
    logic [ADDR_BITS-1:0] ra;
    status_e              st;
  } dir_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CFG_BITS-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;

  // Shadow copy of the liveness table and its timeout
  logic                 mdl_valid [TABLE_ENTRIES];
  logic [ADDR_BITS-1:0] mdl_addr  [TABLE_ENTRIES];
  logic [TIME_BITS-1:0] mdl_seen  [TABLE_ENTRIES];
  logic [TIME_BITS-1:0] mdl_timeout = TIMEOUT_RESET;

  out_t        pending_results [$];
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  bit          quiet        = 1'b0;
  bit          hold_off_req = 1'b0;

  // Directed transactions: empty table, extremes, wrap of the age, full table
  dir_row_t dir_table [DIR_ROWS] = '{
    '{FN_FIRST,     24'h000000, 32'h0000_0000, 1'b1, 24'h000000, ST_NOTHING},
    '{FN_LIST,      24'hFFFFFF, 32'hFFFF_FFFF, 1'b1, 24'h000000, ST_NOTHING},
    '{FN_SCAN,      24'h5A5A5A, 32'h0000_0000, 1'b1, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'h000000, 32'h0000_0000, 1'b1, 24'h000000, ST_INSERTED},
    '{FN_HEARTBEAT, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b1, 24'hFFFFFF, ST_INSERTED},
    '{FN_HEARTBEAT, 24'h000000, 32'h0000_0064, 1'b1, 24'h000000, ST_UPDATED},
    '{FN_FIRST,     24'hA5A5A5, 32'h0000_0000, 1'b1, 24'h000000, ST_LISTED},
    '{FN_SCAN,      24'h000000, 32'h000F_4284, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'h000010, 32'h000F_4300, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'h000300, 32'h000F_4301, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'h5A5A5A, 32'h000F_4302, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'hA5A5A5, 32'h000F_4303, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'h123456, 32'h000F_4304, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'h7FFFFF, 32'h000F_4305, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'h800000, 32'h000F_4306, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'hFEDCBA, 32'h000F_4307, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'h000100, 32'h000F_4308, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'h00FF00, 32'h000F_4309, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'h0F0F0F, 32'h000F_430A, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'hF0F0F0, 32'h000F_430B, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'h3C3C3C, 32'h000F_430C, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'hC3C3C3, 32'h000F_430D, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'h000002, 32'h000F_430E, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_HEARTBEAT, 24'h000003, 32'h000F_430F, 1'b1, 24'h000003, ST_DROPPED},
    '{FN_HEARTBEAT, 24'h5A5A5A, 32'h000F_4400, 1'b0, 24'h000000, ST_NOTHING},
    '{FN_LIST,      24'h000000, 32'h000F_4401, 1'b0, 24'h000000, ST_NOTHING}
  };

  heartbeat_liveness_table i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      mdl_valid[i] = 1'b0;
      mdl_addr[i]  = '0;
      mdl_seen[i]  = '0;
    end
  end

  // Slot of the lowest stored address, optionally strictly above a floor; -1 if none
  function automatic int lowest_above(bit use_floor, logic [ADDR_BITS-1:0] floor_addr);
    int pick;
    pick = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (mdl_valid[i] && !(use_floor && mdl_addr[i] <= floor_addr)) begin
        if (pick < 0) pick = i;
        else if (mdl_addr[i] < mdl_addr[pick]) pick = i;
      end
    end
    return pick;
  endfunction

  // Advance the shadow table by one transaction and queue its results
  task automatic table_predict(input in_t beat, input bit typed, input out_t fixed);
    int                   hit;
    int                   slot;
    int                   cur;
    int                   nxt;
    logic [TIME_BITS-1:0] age;
    out_t                 made [$];
    hit  = -1;
    slot = -1;
    case (beat.func)
      FN_HEARTBEAT: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (mdl_valid[i] && mdl_addr[i] == beat.device_addr && hit < 0) hit = i;
          if (!mdl_valid[i] && slot < 0) slot = i;
        end
        if (hit >= 0) begin
          mdl_seen[hit] = beat.now;
          made.push_back('{beat.device_addr, ST_UPDATED, 1'b1});
        end else if (slot < 0) begin
          made.push_back('{beat.device_addr, ST_DROPPED, 1'b1});
        end else begin
          mdl_valid[slot] = 1'b1;
          mdl_addr[slot]  = beat.device_addr;
          mdl_seen[slot]  = beat.now;
          made.push_back('{beat.device_addr, ST_INSERTED, 1'b1});
        end
      end
      FN_SCAN: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          age = beat.now - mdl_seen[i];
          if (mdl_valid[i] && age > mdl_timeout) begin
            if (hit < 0) hit = i;
            else if (mdl_addr[i] < mdl_addr[hit]) hit = i;
          end
        end
        if (hit < 0) begin
          made.push_back('{'0, ST_NOTHING, 1'b1});
        end else begin
          mdl_valid[hit] = 1'b0;
          made.push_back('{mdl_addr[hit], ST_REMOVED, 1'b1});
        end
      end
      FN_LIST: begin
        cur = lowest_above(1'b0, '0);
        if (cur < 0) made.push_back('{'0, ST_NOTHING, 1'b1});
        while (cur >= 0) begin
          nxt = lowest_above(1'b1, mdl_addr[cur]);
          made.push_back('{mdl_addr[cur], ST_LISTED, nxt < 0});
          cur = nxt;
        end
      end
      default: begin
        cur = lowest_above(1'b0, '0);
        if (cur < 0) made.push_back('{'0, ST_NOTHING, 1'b1});
        else made.push_back('{mdl_addr[cur], ST_LISTED, 1'b1});
      end
    endcase
    if (typed) pending_results.push_back(fixed);
    else foreach (made[i]) pending_results.push_back(made[i]);
  endtask

  // Offer one transaction and hold it until the block takes it
  task automatic offer_beat(input in_t beat, input bit typed, input out_t fixed);
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    table_predict(beat, typed, fixed);
  endtask

  // Drop valid for a random burst now and then
  task automatic sender_pause();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Lower valid and wait for every outstanding result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, one long hold-off on request, none when quiet
  initial begin : receiver
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, actual addr %h status %0d last %0b",
                 $time, out_data_o.result_addr, out_data_o.status, out_data_o.last);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.result_addr !== want.result_addr) begin
          mismatches++;
          $display("%0t ns: result_addr mismatch, expected %h, actual %h",
                   $time, want.result_addr, out_data_o.result_addr);
        end
        if (out_data_o.status !== want.status) begin
          mismatches++;
          $display("%0t ns: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_data_o.status);
        end
        if (out_data_o.last !== want.last) begin
          mismatches++;
          $display("%0t ns: last mismatch, expected %0b, actual %0b",
                   $time, want.last, out_data_o.last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[heartbeat_liveness_table] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    in_t                  beat;
    out_t                 fixed;
    logic [TIME_BITS-1:0] phase_timeout [PHASES];
    logic [TIME_BITS-1:0] sys_now;
    logic [TIME_BITS-1:0] step_max;
    logic [ADDR_BITS-1:0] addr_pool [POOL_MAX];
    int unsigned          pool_len;
    int unsigned          pick;

    phase_timeout = '{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd20, 32'd0};
    phase_timeout[PHASES-1] = $urandom_range(1, 200000);

    // Hold reset, then release at a rising edge
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset timeout
    foreach (dir_table[i]) begin
      beat  = '{dir_table[i].f, dir_table[i].a, dir_table[i].t};
      fixed = '{dir_table[i].ra, dir_table[i].st, 1'b1};
      offer_beat(beat, dir_table[i].typed, fixed);
      sender_pause();
    end

    // Random phases, each under its own timeout; start near the time wrap
    sys_now = 32'hFFFF_0000;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      cfg_we_i   <= 1'b1;
      cfg_data_i <= phase_timeout[ph];
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      mdl_timeout = phase_timeout[ph];
      quiet       = (ph == PHASES - 1);

      if (phase_timeout[ph] == 0) step_max = 3;
      else if (phase_timeout[ph] > 32'h4000_0000) step_max = 32'h4000_0000;
      else step_max = phase_timeout[ph] / 4 + 1;

      // Small address pool so that updates, full table and expiry all occur
      pool_len     = $urandom_range(8, POOL_MAX);
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_MAX; i++) addr_pool[i] = ADDR_BITS'($urandom);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 0 && k == 30) hold_off_req = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 50) beat.func = FN_HEARTBEAT;
        else if (pick < 72) beat.func = FN_SCAN;
        else if (pick < 84) beat.func = FN_LIST;
        else beat.func = FN_FIRST;
        if ($urandom_range(0, 15) == 0) beat.device_addr = ADDR_BITS'($urandom);
        else beat.device_addr = addr_pool[$urandom_range(0, pool_len - 1)];
        if ($urandom_range(0, 19) == 0) sys_now = $urandom;
        else sys_now = sys_now + $urandom_range(0, step_max);
        beat.now = sys_now;
        offer_beat(beat, 1'b0, '0);
        sender_pause();
      end
    end

    // Collect the tail, then report
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[heartbeat_liveness_table] OK");
    end else begin
      $display("[heartbeat_liveness_table] ERROR");
    end
    $finish;
  end

endmodule
